>>> rtl/adri_pkg.sv
// Package for the accelerometer dead-reckoning integrator: widths, reset values,
// microcode field types and the microprogram ROM. Depends on nothing.
`timescale 1ns / 1ps
`default_nettype none

package adri_pkg;

    localparam int FRAC_BITS  = 16;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 21;
    localparam int A_W        = 33;
    localparam int B_W        = 26;
    localparam int PROD_W     = A_W + B_W;
    localparam int ACC_W      = 60;
    localparam int UPC_W      = 5;
    localparam int REC_SHIFT  = 34;

    localparam logic signed [15:0] OFFSET_RST   = 16'sd0;
    localparam logic [15:0]        ALPHA_RST    = 16'd6554;
    localparam logic [20:0]        DEADBAND_RST = 21'd4588;
    localparam logic [7:0]         WARMUP_RST   = 8'd10;
    localparam logic [15:0]        PERIOD_RST   = 16'd655;

    // Scaling by 98 * 2^16 / 10000 is |d| * 642 + floor((|d| * 158 + 312) / 625),
    // and the division by 625 is a multiply by ceil(2^34 / 625).
    localparam logic [B_W-1:0] K_158   = B_W'(158);
    localparam logic [B_W-1:0] K_642   = B_W'(642);
    localparam logic [B_W-1:0] K_REC   = B_W'(27487791);
    localparam logic [B_W-1:0] K_1000  = B_W'(1000);
    localparam logic [ACC_W-1:0] RND_312_VAL = ACC_W'(312);
    localparam logic [ACC_W-1:0] HALF16_VAL  = ACC_W'(1) << (FRAC_BITS - 1);
    localparam logic [ACC_W-1:0] HALF17_VAL  = ACC_W'(1) << FRAC_BITS;

    typedef logic [UPC_W-1:0] upc_t;

    localparam upc_t STEP_IDLE = upc_t'(0);
    localparam upc_t STEP_OUT  = upc_t'(18);
    localparam upc_t LAST_STEP = STEP_OUT;

    typedef enum logic [2:0] {
        REG_ACCEL_OFFSET  = 3'd0,
        REG_FILTER_ALPHA  = 3'd1,
        REG_DEADBAND      = 3'd2,
        REG_WARMUP_TICKS  = 3'd3,
        REG_SAMPLE_PERIOD = 3'd4
    } cfg_reg_t;

    typedef enum logic [2:0] {
        A_ABSD, A_ACC, A_FILT, A_ACCEL, A_SUMA, A_SUMV, A_LOC
    } a_sel_t;

    typedef enum logic [2:0] {
        B_K158, B_K642, B_KREC, B_ALPHAC, B_ALPHA, B_PERIOD, B_K1000
    } b_sel_t;

    typedef enum logic [1:0] {
        ACC_HOLD, ACC_LOAD, ACC_ADD, ACC_ADDQ
    } acc_op_t;

    typedef enum logic [1:0] {
        RND_ZERO, RND_312, RND_HALF16, RND_HALF17
    } rnd_sel_t;

    typedef enum logic [2:0] {
        WB_NONE, WB_ACCEL, WB_FILT, WB_VEL, WB_LOC, WB_POS, WB_OUT
    } wb_sel_t;

    typedef enum logic [2:0] {
        BR_NEXT, BR_WAIT_IN, BR_WARM, BR_WAIT_OUT, BR_JUMP
    } br_sel_t;

    typedef struct packed {
        a_sel_t   a_sel;
        b_sel_t   b_sel;
        acc_op_t  acc_op;
        rnd_sel_t rnd;
        wb_sel_t  wb;
        br_sel_t  br;
        upc_t     target;
    } uword_t;

    function automatic uword_t ucode(input upc_t pc);
        uword_t w;
        w = '{a_sel: A_ABSD, b_sel: B_K158, acc_op: ACC_HOLD, rnd: RND_ZERO,
              wb: WB_NONE, br: BR_NEXT, target: STEP_IDLE};
        case (pc)
            upc_t'(0):  w.br = BR_WAIT_IN;
            upc_t'(1):  begin w.a_sel = A_ABSD; w.b_sel = B_K158; end
            upc_t'(2):  begin w.a_sel = A_ABSD; w.b_sel = B_K642;
                              w.acc_op = ACC_LOAD; w.rnd = RND_312; end
            upc_t'(3):  begin w.a_sel = A_ACC; w.b_sel = B_KREC; w.acc_op = ACC_LOAD; end
            upc_t'(4):  w.acc_op = ACC_ADDQ;
            upc_t'(5):  begin w.a_sel = A_FILT; w.b_sel = B_ALPHAC; w.wb = WB_ACCEL; end
            upc_t'(6):  begin w.a_sel = A_ACCEL; w.b_sel = B_ALPHA;
                              w.acc_op = ACC_LOAD; w.rnd = RND_HALF16; end
            upc_t'(7):  w.acc_op = ACC_ADD;
            upc_t'(8):  begin w.wb = WB_FILT; w.br = BR_WARM; w.target = STEP_OUT; end
            upc_t'(9):  begin w.a_sel = A_SUMA; w.b_sel = B_PERIOD; end
            upc_t'(10): begin w.acc_op = ACC_LOAD; w.rnd = RND_HALF17; end
            upc_t'(11): w.wb = WB_VEL;
            upc_t'(12): begin w.a_sel = A_SUMV; w.b_sel = B_PERIOD; end
            upc_t'(13): begin w.acc_op = ACC_LOAD; w.rnd = RND_HALF17; end
            upc_t'(14): w.wb = WB_LOC;
            upc_t'(15): begin w.a_sel = A_LOC; w.b_sel = B_K1000; end
            upc_t'(16): begin w.acc_op = ACC_LOAD; w.rnd = RND_HALF16; end
            upc_t'(17): w.wb = WB_POS;
            upc_t'(18): begin w.wb = WB_OUT; w.br = BR_WAIT_OUT; w.target = STEP_IDLE; end
            default:    begin w.br = BR_JUMP; w.target = STEP_IDLE; end
        endcase
        return w;
    endfunction

    function automatic logic signed [31:0] sat32(input logic signed [ACC_W-1:0] v);
        logic signed [31:0] r;
        if (v > ACC_W'(64'sh7FFF_FFFF)) begin
            r = 32'sh7FFF_FFFF;
        end
        else if (v < -ACC_W'(64'sh8000_0000)) begin
            r = 32'sh8000_0000;
        end
        else begin
            r = v[31:0];
        end
        return r;
    endfunction

endpackage

`default_nettype wire

>>> rtl/accel_dead_reckoning_integrator_unit.sv
// Top level of the accelerometer dead-reckoning integrator: a microcoded sequencer
// driving one shared multiplier and accumulator. Depends on adri_pkg.
//
//   Channel  Direction  Handshake               Payload
//   in       input      in_valid / in_ready     accel_raw
//   out      output     out_valid / out_ready   position_mm, speed, accel_used, warming
//   cfg      input      cfg_valid / cfg_ready   cfg_index, cfg_data
//
// A word runs through the microprogram into the output register, going from the
// filter step straight to the output step during warm-up. A new word is taken once
// the sequencer is back at its idle step. The output register holds a result until
// it is taken, and the sequencer waits at its last step only while one is still held.
// Reset clears the sequencer, integrator and valid state and loads config defaults.
`timescale 1ns / 1ps
`default_nettype none

module accel_dead_reckoning_integrator_unit
    import adri_pkg::*;
(
    input  wire logic                         clk,
    input  wire logic                         rst_n,
    input  wire logic                         in_valid,
    output logic                              in_ready,
    input  wire logic signed [15:0]           accel_raw,
    output logic                              out_valid,
    input  wire logic                         out_ready,
    output logic signed [31:0]                position_mm,
    output logic signed [31:0]                speed,
    output logic signed [31:0]                accel_used,
    output logic                              warming,
    input  wire logic                         cfg_valid,
    output logic                              cfg_ready,
    input  wire logic [CFG_IDX_W-1:0]         cfg_index,
    input  wire logic [CFG_DATA_W-1:0]        cfg_data
);

    logic signed [15:0]       offset_reg;
    logic [15:0]              alpha_reg;
    logic [20:0]              deadband_reg;
    logic [7:0]               warmup_reg;
    logic [15:0]              period_reg;

    upc_t                     upc_reg, upc_next;
    uword_t                   uw;

    logic [16:0]              absd_reg;
    logic                     dneg_reg;
    logic signed [PROD_W-1:0] prod_reg;
    logic signed [ACC_W-1:0]  acc_reg, acc_next;
    logic signed [31:0]       accel_reg, filt_reg, used_reg, vnow_reg, vprev_reg;
    logic signed [31:0]       aprev_reg, loc_reg, held_reg;
    logic [7:0]               warm_count_reg;
    logic                     warming_reg;

    logic signed [31:0]       pos_out_reg, speed_out_reg, used_out_reg;
    logic                     warm_out_reg, out_valid_reg;

    logic                     in_fire, out_free, warm_now, dead_zone;
    logic signed [16:0]       diff;
    logic signed [A_W-1:0]    mul_a;
    logic signed [B_W-1:0]    mul_b;
    logic signed [ACC_W-1:0]  rnd_val;
    logic signed [31:0]       filt_new;
    logic [31:0]              filt_mag;

    assign uw        = ucode(upc_reg);
    assign in_ready  = (upc_reg == STEP_IDLE);
    assign in_fire   = in_valid && in_ready;
    assign out_free  = !out_valid_reg || out_ready;
    assign warm_now  = warm_count_reg < warmup_reg;
    assign cfg_ready = 1'b1;

    assign diff = {accel_raw[15], accel_raw} - {offset_reg[15], offset_reg};

    assign filt_new  = sat32(acc_reg >>> FRAC_BITS);
    assign filt_mag  = filt_new[31] ? 32'(-filt_new) : 32'(filt_new);
    assign dead_zone = filt_mag <= {11'd0, deadband_reg};

    // Sequencer next step.
    always_comb
    begin
        upc_next = upc_reg + upc_t'(1);
        case (uw.br)
            BR_NEXT:     upc_next = upc_reg + upc_t'(1);
            BR_WAIT_IN:  upc_next = in_fire ? upc_reg + upc_t'(1) : upc_reg;
            BR_WARM:     upc_next = warm_now ? uw.target : upc_reg + upc_t'(1);
            BR_WAIT_OUT: upc_next = out_free ? uw.target : upc_reg;
            BR_JUMP:     upc_next = uw.target;
            default:     upc_next = STEP_IDLE;
        endcase
    end

    // Multiplier operands.
    always_comb
    begin
        case (uw.a_sel)
            A_ABSD:  mul_a = A_W'({1'b0, absd_reg});
            A_ACC:   mul_a = acc_reg[A_W-1:0];
            A_FILT:  mul_a = A_W'(filt_reg);
            A_ACCEL: mul_a = A_W'(accel_reg);
            A_SUMA:  mul_a = A_W'(used_reg) + A_W'(aprev_reg);
            A_SUMV:  mul_a = A_W'(vnow_reg) + A_W'(vprev_reg);
            A_LOC:   mul_a = A_W'(loc_reg);
            default: mul_a = '0;
        endcase
        case (uw.b_sel)
            B_K158:   mul_b = K_158;
            B_K642:   mul_b = K_642;
            B_KREC:   mul_b = K_REC;
            B_ALPHAC: mul_b = B_W'(17'h10000 - {1'b0, alpha_reg});
            B_ALPHA:  mul_b = B_W'(alpha_reg);
            B_PERIOD: mul_b = B_W'(period_reg);
            B_K1000:  mul_b = K_1000;
            default:  mul_b = '0;
        endcase
    end

    // Accumulator.
    always_comb
    begin
        case (uw.rnd)
            RND_ZERO:   rnd_val = '0;
            RND_312:    rnd_val = RND_312_VAL;
            RND_HALF16: rnd_val = HALF16_VAL;
            RND_HALF17: rnd_val = HALF17_VAL;
            default:    rnd_val = '0;
        endcase
        case (uw.acc_op)
            ACC_HOLD: acc_next = acc_reg;
            ACC_LOAD: acc_next = ACC_W'(prod_reg) + rnd_val;
            ACC_ADD:  acc_next = acc_reg + ACC_W'(prod_reg);
            ACC_ADDQ: acc_next = acc_reg + ACC_W'(prod_reg >>> REC_SHIFT);
            default:  acc_next = acc_reg;
        endcase
    end

    always_ff @(posedge clk)
    begin
        prod_reg <= PROD_W'(mul_a) * PROD_W'(mul_b);
        acc_reg  <= acc_next;
        if (in_fire)
        begin
            absd_reg <= diff[16] ? 17'(-diff) : 17'(diff);
            dneg_reg <= diff[16];
        end
        if (uw.wb == WB_ACCEL)
        begin
            accel_reg <= dneg_reg ? -acc_reg[31:0] : acc_reg[31:0];
        end
        if (uw.wb == WB_OUT && out_free)
        begin
            pos_out_reg   <= held_reg;
            speed_out_reg <= vnow_reg;
            used_out_reg  <= used_reg;
            warm_out_reg  <= warming_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            upc_reg        <= STEP_IDLE;
            offset_reg     <= OFFSET_RST;
            alpha_reg      <= ALPHA_RST;
            deadband_reg   <= DEADBAND_RST;
            warmup_reg     <= WARMUP_RST;
            period_reg     <= PERIOD_RST;
            filt_reg       <= '0;
            used_reg       <= '0;
            vnow_reg       <= '0;
            vprev_reg      <= '0;
            aprev_reg      <= '0;
            loc_reg        <= '0;
            held_reg       <= '0;
            warm_count_reg <= '0;
            warming_reg    <= 1'b0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            upc_reg <= upc_next;
            if (cfg_valid && cfg_ready)
            begin
                case (cfg_index)
                    REG_ACCEL_OFFSET:  offset_reg   <= cfg_data[15:0];
                    REG_FILTER_ALPHA:  alpha_reg    <= cfg_data[15:0];
                    REG_DEADBAND:      deadband_reg <= cfg_data[20:0];
                    REG_WARMUP_TICKS:  warmup_reg   <= cfg_data[7:0];
                    REG_SAMPLE_PERIOD: period_reg   <= cfg_data[15:0];
                    default:           ;
                endcase
            end
            case (uw.wb)
                WB_FILT:
                begin
                    filt_reg    <= filt_new;
                    used_reg    <= dead_zone ? 32'sd0 : filt_new;
                    warming_reg <= warm_now;
                    if (dead_zone)
                    begin
                        vnow_reg <= '0;
                    end
                    if (warm_now)
                    begin
                        warm_count_reg <= warm_count_reg + 8'd1;
                    end
                end
                WB_VEL:
                begin
                    vnow_reg <= sat32(ACC_W'(vnow_reg) + (acc_reg >>> (FRAC_BITS + 1)));
                end
                WB_LOC:
                begin
                    loc_reg <= sat32(ACC_W'(loc_reg) + (acc_reg >>> (FRAC_BITS + 1)));
                end
                WB_POS:
                begin
                    held_reg  <= sat32(acc_reg >>> FRAC_BITS);
                    aprev_reg <= used_reg;
                    vprev_reg <= vnow_reg;
                end
                default:
                begin
                end
            endcase
            if (uw.wb == WB_OUT && out_free)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    assign out_valid   = out_valid_reg;
    assign position_mm = pos_out_reg;
    assign speed       = speed_out_reg;
    assign accel_used  = used_out_reg;
    assign warming     = warm_out_reg;

    // A word accepted at the idle step leaves the sequencer busy on the next cycle.
    assert property (@(posedge clk) disable iff (!rst_n) in_fire |=> !in_ready)
        else $error("sequencer did not leave the idle step after an input word");

    // A new result appears only as the sequencer returns to its idle step.
    assert property (@(posedge clk) disable iff (!rst_n) $rose(out_valid) |-> in_ready)
        else $error("result loaded outside the output step");

    // Position is only updated for a word that is past warm-up.
    assert property (@(posedge clk) disable iff (!rst_n) (uw.wb == WB_POS) |-> !warming_reg)
        else $error("position written during warm-up");

    // The step counter stays within the microprogram.
    assert property (@(posedge clk) disable iff (!rst_n) upc_reg <= LAST_STEP)
        else $error("step counter outside the microprogram");

endmodule

`default_nettype wire
